FILE: hdl/axr_pkg.sv
// axr_pkg: shared widths, register indexes, types and the saturation helper
// for the axis mean reducer. No dependencies.
`timescale 1ns / 1ps

package axr_pkg;

    localparam int MAX_AXIS_DEF  = 4096;
    localparam int MAX_INNER_DEF = 1024;

    localparam int ELEM_W    = 16;
    localparam int SUM_W     = 28;
    localparam int SUMX_W    = SUM_W + 2;
    localparam int COL_OUT_W = 10;
    localparam int FRAC_W    = 16;

    localparam int AXIS_W  = 13;
    localparam int INNER_W = 11;
    localparam int OUTER_W = 24;
    localparam int SCALE_W = 17;
    localparam int PROD_W  = SUM_W + SCALE_W + 1;

    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 3;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_LENGTH      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_LENGTH     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTER_COUNT      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MEAN_MODE        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RECIPROCAL_SCALE = 3'd4;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    typedef struct packed {
        logic [AXIS_W-1:0]  axis_length;
        logic [INNER_W-1:0] inner_length;
        logic [OUTER_W-1:0] outer_count;
        logic               mean_mode;
        logic [SCALE_W-1:0] reciprocal_scale;
    } axr_cfg_t;

    typedef struct packed {
        logic first_row;
        logic last_row;
        logic final_flag;
    } axr_flags_t;

    function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [SUMX_W-1:0] v);
        logic signed [SUM_W-1:0] r;
        if (v > SUMX_W'(SUM_MAX)) begin
            r = SUM_MAX;
        end else if (v < SUMX_W'(SUM_MIN)) begin
            r = SUM_MIN;
        end else begin
            r = SUM_W'(v);
        end
        return r;
    endfunction

endpackage

FILE: hdl/axr_front.sv
// axr_front: accepts elements, tracks row/column/slab position and tags each
// request with its column and flags. Depends on axr_pkg.
`timescale 1ns / 1ps

module axr_front import axr_pkg::*; #(
    parameter int MAX_AXIS  = MAX_AXIS_DEF,
    parameter int MAX_INNER = MAX_INNER_DEF,
    parameter int COL_W     = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  axr_cfg_t                 cfg,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [ELEM_W-1:0] s_element_value,
    input  logic                     q_full,
    output logic                     push,
    output logic signed [ELEM_W-1:0] push_value,
    output logic [COL_W-1:0]         push_col,
    output axr_flags_t               push_flags
);

    localparam int ROW_W = (MAX_AXIS > 1) ? $clog2(MAX_AXIS) : 1;
    localparam int CMP_W = 18;

    logic [ROW_W-1:0]   row_reg;
    logic [COL_W-1:0]   col_reg;
    logic [OUTER_W-1:0] slab_reg;

    logic [AXIS_W-1:0]  axis_eff;
    logic [INNER_W-1:0] inner_eff;
    logic [OUTER_W-1:0] outer_eff;
    logic               last_row;
    logic               last_col;
    logic               last_slab;

    always_comb begin
        if (cfg.axis_length == '0) begin
            axis_eff = AXIS_W'(1);
        end else if (CMP_W'(cfg.axis_length) > CMP_W'(MAX_AXIS)) begin
            axis_eff = AXIS_W'(MAX_AXIS);
        end else begin
            axis_eff = cfg.axis_length;
        end
        if (cfg.inner_length == '0) begin
            inner_eff = INNER_W'(1);
        end else if (CMP_W'(cfg.inner_length) > CMP_W'(MAX_INNER)) begin
            inner_eff = INNER_W'(MAX_INNER);
        end else begin
            inner_eff = cfg.inner_length;
        end
        outer_eff = (cfg.outer_count == '0) ? OUTER_W'(1) : cfg.outer_count;
    end

    assign last_row  = (CMP_W'(row_reg) + CMP_W'(1)) >= CMP_W'(axis_eff);
    assign last_col  = (CMP_W'(col_reg) + CMP_W'(1)) >= CMP_W'(inner_eff);
    assign last_slab = ({1'b0, slab_reg} + (OUTER_W+1)'(1)) >= {1'b0, outer_eff};

    assign s_ready               = !q_full;
    assign push                  = s_valid && !q_full;
    assign push_value            = s_element_value;
    assign push_col              = col_reg;
    assign push_flags.first_row  = (row_reg == '0);
    assign push_flags.last_row   = last_row;
    assign push_flags.final_flag = last_row && last_col && last_slab;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg  <= '0;
            col_reg  <= '0;
            slab_reg <= '0;
        end else if (push) begin
            if (last_col) begin
                col_reg <= '0;
                if (last_row) begin
                    row_reg  <= '0;
                    slab_reg <= last_slab ? '0 : slab_reg + OUTER_W'(1);
                end else begin
                    row_reg <= row_reg + ROW_W'(1);
                end
            end else begin
                col_reg <= col_reg + COL_W'(1);
            end
        end
    end

endmodule

FILE: hdl/axr_queue.sv
// axr_queue: short request queue between front and back.
// Depends on axr_pkg for the default depth.
`timescale 1ns / 1ps

module axr_queue import axr_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CW'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule

FILE: hdl/axr_back.sv
// axr_back: accumulator memory read-modify-write with forwarding, mean
// scaling multiply and output register. Depends on axr_pkg.
`timescale 1ns / 1ps

module axr_back import axr_pkg::*; #(
    parameter int MAX_INNER = MAX_INNER_DEF,
    parameter int COL_W     = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     mean_mode,
    input  logic [SCALE_W-1:0]       reciprocal_scale,
    input  logic                     q_empty,
    output logic                     pop,
    input  logic signed [ELEM_W-1:0] pop_value,
    input  logic [COL_W-1:0]         pop_col,
    input  axr_flags_t               pop_flags,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [SUM_W-1:0]  m_result_value,
    output logic [COL_W-1:0]         m_column_index,
    output logic                     m_final_result
);

    logic signed [SUM_W-1:0] mem [MAX_INNER];

    logic                     en;
    logic                     wr_en;

    logic                     s1_valid_reg;
    logic signed [ELEM_W-1:0] s1_value_reg;
    logic [COL_W-1:0]         s1_col_reg;
    axr_flags_t               s1_flags_reg;
    logic signed [SUM_W-1:0]  rd_data_reg;

    logic                     fw_valid_reg;
    logic [COL_W-1:0]         fw_col_reg;
    logic signed [SUM_W-1:0]  fw_data_reg;

    logic signed [SUM_W-1:0]  acc;
    logic signed [SUM_W-1:0]  sum_s1;

    logic                     s2_valid_reg;
    logic signed [SUM_W-1:0]  s2_sum_reg;
    logic [COL_W-1:0]         s2_col_reg;
    logic                     s2_final_reg;

    logic                     s3_valid_reg;
    logic signed [PROD_W-1:0] s3_prod_reg;
    logic signed [SUM_W-1:0]  s3_sum_reg;
    logic [COL_W-1:0]         s3_col_reg;
    logic                     s3_final_reg;

    logic                     out_valid_reg;
    logic signed [SUM_W-1:0]  out_value_reg;
    logic [COL_W-1:0]         out_col_reg;
    logic                     out_final_reg;

    logic signed [SUM_W-1:0]  result_s3;

    assign en    = !(out_valid_reg && !m_ready);
    assign pop   = en && !q_empty;
    assign wr_en = en && s1_valid_reg;

    // newest write wins over the registered read, which misses it
    assign acc = (fw_valid_reg && (fw_col_reg == s1_col_reg)) ? fw_data_reg : rd_data_reg;

    always_comb begin
        if (s1_flags_reg.first_row) begin
            sum_s1 = SUM_W'(s1_value_reg);
        end else begin
            sum_s1 = sat_sum(SUMX_W'(acc) + SUMX_W'(s1_value_reg));
        end
    end

    assign result_s3 = mean_mode ? sat_sum(SUMX_W'(s3_prod_reg >>> FRAC_W)) : s3_sum_reg;

    always_ff @(posedge aclk) begin
        if (pop) begin
            rd_data_reg <= mem[pop_col];
        end
        if (wr_en) begin
            mem[s1_col_reg] <= sum_s1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_value_reg  <= pop_value;
            s1_col_reg    <= pop_col;
            s1_flags_reg  <= pop_flags;
            s2_sum_reg    <= sum_s1;
            s2_col_reg    <= s1_col_reg;
            s2_final_reg  <= s1_flags_reg.final_flag;
            s3_prod_reg   <= s2_sum_reg * $signed({1'b0, reciprocal_scale});
            s3_sum_reg    <= s2_sum_reg;
            s3_col_reg    <= s2_col_reg;
            s3_final_reg  <= s2_final_reg;
            out_value_reg <= result_s3;
            out_col_reg   <= s3_col_reg;
            out_final_reg <= s3_final_reg;
        end
        if (wr_en) begin
            fw_col_reg  <= s1_col_reg;
            fw_data_reg <= sum_s1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            fw_valid_reg  <= 1'b0;
        end else begin
            if (en) begin
                s1_valid_reg  <= pop;
                s2_valid_reg  <= s1_valid_reg && s1_flags_reg.last_row;
                s3_valid_reg  <= s2_valid_reg;
                out_valid_reg <= s3_valid_reg;
            end
            if (wr_en) begin
                fw_valid_reg <= 1'b1;
            end
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_result_value = out_value_reg;
    assign m_column_index = out_col_reg;
    assign m_final_result = out_final_reg;

endmodule

FILE: hdl/axis_mean_reducer.sv
// axis_mean_reducer: top level; configuration registers, front, request
// queue and back. Depends on axr_pkg, axr_front, axr_queue, axr_back.
`timescale 1ns / 1ps

// Reduces a streamed tensor along one axis, one element per cycle. Elements
// arrive in memory order (slab, axis row, inner column); one 28 bit result
// per column leaves on the last axis row, either the saturated sum or, in
// mean mode, the sum times reciprocal_scale shifted right by 16 (floor). The
// block takes one element every cycle while the result side keeps up; the
// rate is set by the read-modify-write of the per-column accumulator memory
// (MAX_INNER x 28 bits, one read and one write per cycle), whose back-to-back
// hazard on the same column is covered by forwarding the last write. The
// element closing a column passes the queue, s1, s2, s3 and output register
// before m_valid rises. A four-request queue lets input keep flowing while a
// result waits. Accumulators are not cleared at reset: every column must see
// a first axis row before it is summed into. Configure only while idle.
module axis_mean_reducer import axr_pkg::*; #(
    parameter int MAX_AXIS  = MAX_AXIS_DEF,
    parameter int MAX_INNER = MAX_INNER_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]            cfg_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [ELEM_W-1:0]    s_element_value,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [SUM_W-1:0]     m_result_value,
    output logic [COL_OUT_W-1:0]        m_column_index,
    output logic                        m_final_result
);

    localparam int COL_W = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
    localparam int QW    = ELEM_W + COL_W + $bits(axr_flags_t);

    axr_cfg_t                 cfg_reg;

    logic                     push;
    logic signed [ELEM_W-1:0] push_value;
    logic [COL_W-1:0]         push_col;
    axr_flags_t               push_flags;
    logic                     q_full;
    logic                     q_empty;
    logic                     pop;
    logic [QW-1:0]            pop_data;
    logic signed [ELEM_W-1:0] pop_value;
    logic [COL_W-1:0]         pop_col;
    axr_flags_t               pop_flags;
    logic [COL_W-1:0]         back_col;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.axis_length      <= AXIS_W'(1);
            cfg_reg.inner_length     <= INNER_W'(1);
            cfg_reg.outer_count      <= OUTER_W'(1);
            cfg_reg.mean_mode        <= 1'b1;
            cfg_reg.reciprocal_scale <= SCALE_W'(65536);
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_AXIS_LENGTH:      cfg_reg.axis_length      <= cfg_data[AXIS_W-1:0];
                CFG_INNER_LENGTH:     cfg_reg.inner_length     <= cfg_data[INNER_W-1:0];
                CFG_OUTER_COUNT:      cfg_reg.outer_count      <= cfg_data[OUTER_W-1:0];
                CFG_MEAN_MODE:        cfg_reg.mean_mode        <= cfg_data[0];
                CFG_RECIPROCAL_SCALE: cfg_reg.reciprocal_scale <= cfg_data[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    axr_front #(
        .MAX_AXIS  (MAX_AXIS),
        .MAX_INNER (MAX_INNER),
        .COL_W     (COL_W)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_element_value (s_element_value),
        .q_full          (q_full),
        .push            (push),
        .push_value      (push_value),
        .push_col        (push_col),
        .push_flags      (push_flags)
    );

    axr_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data ({push_value, push_col, push_flags}),
        .full      (q_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (q_empty)
    );

    assign {pop_value, pop_col, pop_flags} = pop_data;

    axr_back #(
        .MAX_INNER (MAX_INNER),
        .COL_W     (COL_W)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .mean_mode        (cfg_reg.mean_mode),
        .reciprocal_scale (cfg_reg.reciprocal_scale),
        .q_empty          (q_empty),
        .pop              (pop),
        .pop_value        (pop_value),
        .pop_col          (pop_col),
        .pop_flags        (pop_flags),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_result_value   (m_result_value),
        .m_column_index   (back_col),
        .m_final_result   (m_final_result)
    );

    assign m_column_index = COL_OUT_W'(back_col);

endmodule

FILE: hdl/axr_checker.sv
// axr_checker: port-level assertions for axis_mean_reducer, bound to the top
// level. Depends on axr_pkg.
`timescale 1ns / 1ps

module axr_checker import axr_pkg::*; (
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     s_valid,
    input logic                     s_ready,
    input logic                     m_valid,
    input logic                     m_ready,
    input logic signed [SUM_W-1:0]  m_result_value,
    input logic [COL_OUT_W-1:0]     m_column_index,
    input logic                     m_final_result
);

    // nothing pending straight after reset
    a_reset_no_result: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_reset_ready: assert property (@(posedge aclk) !aresetn |=> s_ready)
        else $error("input not ready after reset");

    // queue can only fill while the result side stalls
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> $past(m_valid && !m_ready))
        else $error("input stalled without a stalled result");

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_value)
            && $stable(m_column_index) && $stable(m_final_result))
        else $error("stalled result changed");

endmodule

bind axis_mean_reducer axr_checker u_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_result_value (m_result_value),
    .m_column_index (m_column_index),
    .m_final_result (m_final_result)
);

FILE: dv/axis_mean_reducer_tb.sv
// axis_mean_reducer_tb: self-checking testbench for axis_mean_reducer. A local
// predictor tracks the per-column sums and position counters, and results are
// compared in order. Depends on axr_pkg and axis_mean_reducer.
`timescale 1ns / 1ps

module axis_mean_reducer_tb;
    import axr_pkg::*;

    localparam int     WATCHDOG_LIMIT = 2000;
    localparam int     SETTLE_CYCLES  = 20;
    localparam int     HOLD_CYCLES    = 300;
    localparam int     RANDOM_ITEMS   = 440;
    localparam int     OUTER_CAP      = 16777215;
    localparam longint SUM_HI         = 134217727;
    localparam longint SUM_LO         = -134217728;

    typedef enum int {RX_FREE, RX_RANDOM, RX_PERIODIC} rx_mode_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] value;
        logic [COL_OUT_W-1:0]    column;
        logic                    last;
    } reduced_t;

    logic                     aclk;
    logic                     aresetn;
    logic                     cfg_we;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [CFG_W-1:0]         cfg_data;
    logic                     s_valid;
    logic                     s_ready;
    logic signed [ELEM_W-1:0] s_element_value;
    logic                     m_valid;
    logic                     m_ready;
    logic signed [SUM_W-1:0]  m_result_value;
    logic [COL_OUT_W-1:0]     m_column_index;
    logic                     m_final_result;

    // predictor state
    int       axis_reg  = 1;
    int       inner_reg = 1;
    int       outer_reg = 1;
    int       mean_reg  = 1;
    int       scale_reg = 65536;
    longint   column_acc [MAX_INNER_DEF];
    bit       col_written [MAX_INNER_DEF];
    int       row_pos   = 0;
    int       col_pos   = 0;
    int       slab_pos  = 0;
    reduced_t pending_results [$];

    int       mismatch_count = 0;
    int       idle_cycles    = 0;
    rx_mode_t rx_mode        = RX_RANDOM;
    bit       gaps_on        = 1'b1;
    bit       hold_req       = 1'b0;
    int       burst_left     = 0;

    axis_mean_reducer u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_element_value (s_element_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result_value  (m_result_value),
        .m_column_index  (m_column_index),
        .m_final_result  (m_final_result)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin : result_check
        reduced_t want;
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", longint'(m_result_value), 0);
            end else begin
                want = pending_results.pop_front();
                if (m_result_value !== want.value)
                    report_mismatch("result_value", longint'(m_result_value),
                                    longint'(want.value));
                if (m_column_index !== want.column)
                    report_mismatch("column_index", m_column_index, want.column);
                if (m_final_result !== want.last)
                    report_mismatch("final_result", m_final_result, want.last);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid === 1'b1 && s_ready === 1'b1) || (m_valid === 1'b1 && m_ready === 1'b1))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // result side: long hold-off on request, else the selected stall pattern
    initial begin : result_sink
        int hold_left;
        int phase;
        hold_left = 0;
        phase     = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            phase = (phase + 1) % 7;
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                case (rx_mode)
                    RX_FREE:   m_ready <= 1'b1;
                    RX_RANDOM: m_ready <= ($urandom_range(0, 3) != 0);
                    default:   m_ready <= (phase < 4);
                endcase
            end
        end
    end

    function automatic int eff_length(input int v, input int cap);
        if (v == 0) return 1;
        if (v > cap) return cap;
        return v;
    endfunction

    function automatic longint clamp_sum(input longint v);
        if (v > SUM_HI) return SUM_HI;
        if (v < SUM_LO) return SUM_LO;
        return v;
    endfunction

    function automatic int tensor_items();
        return eff_length(axis_reg, MAX_AXIS_DEF) * eff_length(inner_reg, MAX_INNER_DEF)
             * eff_length(outer_reg, OUTER_CAP);
    endfunction

    // later rows must only read columns loaded at some point
    function automatic bit inner_is_safe(input int raw);
        int n;
        n = eff_length(raw, MAX_INNER_DEF);
        if (row_pos == 0) return 1'b1;
        for (int c = 0; c < n; c++)
            if (!col_written[c]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic logic signed [ELEM_W-1:0] random_element();
        case ($urandom_range(0, 9))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return 16'sh0000;
            3:       return 16'shFFFF;
            default: return ELEM_W'($urandom);
        endcase
    endfunction

    task automatic accumulate_element(input logic signed [ELEM_W-1:0] v);
        int       axis_n;
        int       inner_n;
        int       outer_n;
        int       col;
        bit       last_row;
        bit       last_col;
        bit       last_slab;
        longint   total;
        longint   q;
        reduced_t r;
        axis_n    = eff_length(axis_reg, MAX_AXIS_DEF);
        inner_n   = eff_length(inner_reg, MAX_INNER_DEF);
        outer_n   = eff_length(outer_reg, OUTER_CAP);
        col       = (col_pos >= MAX_INNER_DEF) ? MAX_INNER_DEF - 1 : col_pos;
        last_row  = (row_pos + 1 >= axis_n);
        last_col  = (col_pos + 1 >= inner_n);
        last_slab = (slab_pos + 1 >= outer_n);
        total = (row_pos == 0) ? longint'(v) : clamp_sum(column_acc[col] + longint'(v));
        column_acc[col]  = total;
        col_written[col] = 1'b1;
        if (last_row) begin
            q = mean_reg ? clamp_sum((total * longint'(scale_reg)) >>> FRAC_W) : total;
            r.value  = q[SUM_W-1:0];
            r.column = col[COL_OUT_W-1:0];
            r.last   = last_col && last_slab;
            pending_results.push_back(r);
        end
        if (last_col) begin
            col_pos = 0;
            if (last_row) begin
                row_pos  = 0;
                slab_pos = last_slab ? 0 : slab_pos + 1;
            end else begin
                row_pos = row_pos + 1;
            end
        end else begin
            col_pos = col + 1;
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(value);
        @(posedge aclk);
        case (idx)
            CFG_AXIS_LENGTH:      axis_reg  = value & 'h1FFF;
            CFG_INNER_LENGTH:     inner_reg = value & 'h7FF;
            CFG_OUTER_COUNT:      outer_reg = value & 'hFFFFFF;
            CFG_MEAN_MODE:        mean_reg  = value & 'h1;
            CFG_RECIPROCAL_SCALE: scale_reg = value & 'h1FFFF;
            default: ;
        endcase
    endtask

    task automatic configure(input int axis, input int inner, input int outer,
                             input int mean, input int scale);
        write_reg(CFG_AXIS_LENGTH, axis);
        write_reg(CFG_INNER_LENGTH, inner);
        write_reg(CFG_OUTER_COUNT, outer);
        write_reg(CFG_MEAN_MODE, mean);
        write_reg(CFG_RECIPROCAL_SCALE, scale);
        cfg_we <= 1'b0;
    endtask

    // one request on the input side, then, with gaps on, a gap once the burst runs out
    task automatic send_element(input logic signed [ELEM_W-1:0] v);
        s_valid         <= 1'b1;
        s_element_value <= v;
        do @(posedge aclk); while (s_ready !== 1'b1);
        accumulate_element(v);
        if (gaps_on) begin
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
                burst_left = $urandom_range(0, 12);
            end
        end
    endtask

    task automatic send_items(input int n, input bit use_fixed,
                              input logic signed [ELEM_W-1:0] fixed_value);
        for (int i = 0; i < n; i++)
            send_element(use_fixed ? fixed_value : random_element());
    endtask

    // drain all outstanding results, then cover the pipeline latency
    task automatic settle();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic test_reset_defaults();
        send_element(16'sh7FFF);
        send_element(16'sh8000);
        send_element(16'sh0000);
        send_element(16'shFFFF);
        send_element(16'sh5555);
    endtask

    task automatic test_sum_mode();
        settle();
        configure(2, 3, 1, 0, 65536);
        send_items(6, 1'b0, '0);
    endtask

    task automatic test_mean_floor();
        settle();
        configure(3, 2, 1, 1, 21845);
        send_items(6, 1'b1, 16'shFFFF);
    endtask

    task automatic test_zero_lengths();
        settle();
        configure(0, 0, 0, 1, 0);
        send_items(3, 1'b0, '0);
    endtask

    // counters past the new last position act as the last one
    task automatic test_mid_tensor_change();
        settle();
        configure(4, 3, 1, 1, 65536);
        send_items(7, 1'b0, '0);
        settle();
        configure(2, 3, 1, 0, 0);
        send_items(2, 1'b0, '0);
    endtask

    task automatic test_outer_wrap();
        settle();
        configure(1, 3, OUTER_CAP, 0, 0);
        send_items(9, 1'b0, '0);
        settle();
        configure(1, 3, 2, 0, 0);
        send_items(3, 1'b0, '0);
    endtask

    // oversized axis keeps the row open; a shorter axis then closes it
    task automatic test_long_axis();
        settle();
        configure(8191, 1, 1, 1, 131071);
        send_items(12, 1'b1, 16'sh7FFF);
        settle();
        configure(13, 1, 1, 1, 131071);
        send_items(1, 1'b1, 16'sh7FFF);
    endtask

    // oversized inner count keeps columns going; a shorter one then ends the tensor
    task automatic test_wide_inner();
        settle();
        configure(1, 2047, 1, 1, 32768);
        send_items(48, 1'b0, '0);
        settle();
        configure(1, 49, 1, 0, 65536);
        send_items(1, 1'b0, '0);
    endtask

    task automatic test_output_backpressure();
        settle();
        configure(1, 5, 3, 0, 65536);
        rx_mode  = RX_FREE;
        gaps_on  = 1'b0;
        hold_req = 1'b1;
        send_items(60, 1'b0, '0);
        gaps_on  = 1'b1;
        rx_mode  = RX_RANDOM;
    endtask

    task automatic test_random_tensors();
        int sent;
        int axis;
        int inner;
        int outer;
        int scale;
        int n;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            settle();
            rx_mode = rx_mode_t'($urandom_range(0, 2));
            gaps_on = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 9))
                0:       axis = 0;
                1:       axis = $urandom_range(7, 40);
                default: axis = $urandom_range(1, 6);
            endcase
            case ($urandom_range(0, 9))
                0:       inner = 0;
                1:       inner = $urandom_range(9, 32);
                default: inner = $urandom_range(1, 8);
            endcase
            if (!inner_is_safe(inner)) inner = inner_reg;
            outer = (axis > 6 && inner > 8) ? 1 : $urandom_range(0, 3);
            case ($urandom_range(0, 5))
                0:       scale = 65536;
                1:       scale = 131071;
                2:       scale = 0;
                3:       scale = $urandom_range(0, 131071);
                default: scale = 65536 / eff_length(axis, MAX_AXIS_DEF);
            endcase
            configure(axis, inner, outer, $urandom_range(0, 1), scale);
            n = tensor_items() * $urandom_range(1, 2);
            // some phases stop part-way through a tensor
            if ($urandom_range(0, 3) == 0) n += $urandom_range(1, tensor_items());
            if (n > RANDOM_ITEMS - sent) n = RANDOM_ITEMS - sent;
            send_items(n, 1'b0, '0);
            sent += n;
        end
    endtask

    initial begin
        aresetn         <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_index       <= CFG_AXIS_LENGTH;
        cfg_data        <= '0;
        s_valid         <= 1'b0;
        s_element_value <= '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_sum_mode();
        test_mean_floor();
        test_zero_lengths();
        test_mid_tensor_change();
        test_outer_wrap();
        test_long_axis();
        test_wide_inner();
        test_output_backpressure();
        test_random_tensors();

        settle();
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
